@@ src/frustum_culling_test_top_assert.svh @@
// Assertion macros for the culling RTL.
// The module that uses them has clk and arst_n in scope.
`ifndef FRUSTUM_CULLING_TEST_TOP_ASSERT_SVH
`define FRUSTUM_CULLING_TEST_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define FCT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/fct_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;
	localparam int NUM_PLANES     = 6;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 64;
	localparam int CMD_W          = 2;
	localparam int FIELD_W        = 16;
	localparam int RADIUS_W       = 15;
	localparam int NORM_W         = 16;
	localparam int ALIGN_SHIFT    = 14;
	localparam int COORD_BITS_DEF = 16;

	localparam logic [CMD_W-1:0] CMD_POINT  = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_SPHERE = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_BOX    = CMD_W'(2);

	typedef struct packed {
		logic signed [NORM_W-1:0] d;
		logic signed [NORM_W-1:0] nz;
		logic signed [NORM_W-1:0] ny;
		logic signed [NORM_W-1:0] nx;
	} plane_t;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} stage_en_t;
endpackage

`default_nettype wire

@@ src/fct_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fct_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [fct_pkg::CFG_IDX_W-1:0]     idx;
	logic [fct_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, idx, data, input ready);
	modport sink (input valid, idx, data, output ready);
endinterface

`default_nettype wire

@@ src/fct_obj_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fct_obj_if;
	logic                                valid;
	logic                                ready;
	logic [fct_pkg::CMD_W-1:0]           command;
	logic signed [fct_pkg::FIELD_W-1:0]  x_a;
	logic signed [fct_pkg::FIELD_W-1:0]  y_a;
	logic signed [fct_pkg::FIELD_W-1:0]  z_a;
	logic signed [fct_pkg::FIELD_W-1:0]  x_b;
	logic signed [fct_pkg::FIELD_W-1:0]  y_b;
	logic signed [fct_pkg::FIELD_W-1:0]  z_b;
	logic [fct_pkg::RADIUS_W-1:0]        radius;

	modport source (output valid, command, x_a, y_a, z_a, x_b, y_b, z_b, radius,
		input ready);
	modport sink (input valid, command, x_a, y_a, z_a, x_b, y_b, z_b, radius,
		output ready);
endinterface

`default_nettype wire

@@ src/fct_res_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface fct_res_if;
	logic valid;
	logic ready;
	logic visible;
	logic straddles;

	modport source (output valid, visible, straddles, input ready);
	modport sink (input valid, visible, straddles, output ready);
endinterface

`default_nettype wire

@@ src/fct_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fct_cfg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	fct_cfg_if.sink         cfg,
	output fct_pkg::plane_t planes [fct_pkg::NUM_PLANES]
);
	fct_pkg::plane_t planes_q [fct_pkg::NUM_PLANES];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
				planes_q[i] <= '0;
			end
		end else if (cfg.valid) begin
			// drop writes beyond the last plane
			for (int i = 0; i < fct_pkg::NUM_PLANES; i++) begin
				if (cfg.idx == fct_pkg::CFG_IDX_W'(i)) begin
					planes_q[i] <= fct_pkg::plane_t'(cfg.data);
				end
			end
		end
	end

	assign planes = planes_q;
endmodule

`default_nettype wire

@@ src/fct_plane.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fct_plane #(
	parameter int COORD_W = fct_pkg::COORD_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire fct_pkg::stage_en_t                en,
	input  wire fct_pkg::plane_t                   plane,
	input  wire logic                              is_box_s1,
	input  wire logic signed [COORD_W-1:0]         ax_s1,
	input  wire logic signed [COORD_W-1:0]         ay_s1,
	input  wire logic signed [COORD_W-1:0]         az_s1,
	input  wire logic signed [COORD_W-1:0]         bx_s1,
	input  wire logic signed [COORD_W-1:0]         by_s1,
	input  wire logic signed [COORD_W-1:0]         bz_s1,
	input  wire logic [fct_pkg::RADIUS_W-1:0]      sub_s2,
	output logic                                   near_gt_s3,
	output logic                                   far_ge_s3
);
	localparam int PW = fct_pkg::NORM_W + COORD_W;
	localparam int AW = fct_pkg::NORM_W + fct_pkg::ALIGN_SHIFT;
	localparam int SW = ((PW > AW) ? PW : AW) + 3;

	logic px, py, pz;
	logic signed [COORD_W-1:0] nx_c, ny_c, nz_c, fx_c, fy_c, fz_c;
	logic signed [PW-1:0] pnx, pny, pnz, pfx, pfy, pfz;
	logic signed [PW-1:0] pnx_s2, pny_s2, pnz_s2, pfx_s2, pfy_s2, pfz_s2;
	logic signed [fct_pkg::NORM_W-1:0] d_s2;
	logic signed [SW-1:0] d_term, s_term, sum_n, sum_f;

	assign px = plane.nx > 0;
	assign py = plane.ny > 0;
	assign pz = plane.nz > 0;

	// point and sphere use the first corner for both distances
	assign nx_c = (is_box_s1 && !px) ? bx_s1 : ax_s1;
	assign ny_c = (is_box_s1 && !py) ? by_s1 : ay_s1;
	assign nz_c = (is_box_s1 && !pz) ? bz_s1 : az_s1;
	assign fx_c = (is_box_s1 && px) ? bx_s1 : ax_s1;
	assign fy_c = (is_box_s1 && py) ? by_s1 : ay_s1;
	assign fz_c = (is_box_s1 && pz) ? bz_s1 : az_s1;

	assign pnx = PW'(plane.nx) * PW'(nx_c);
	assign pny = PW'(plane.ny) * PW'(ny_c);
	assign pnz = PW'(plane.nz) * PW'(nz_c);
	assign pfx = PW'(plane.nx) * PW'(fx_c);
	assign pfy = PW'(plane.ny) * PW'(fy_c);
	assign pfz = PW'(plane.nz) * PW'(fz_c);

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			pnx_s2 <= pnx;
			pny_s2 <= pny;
			pnz_s2 <= pnz;
			pfx_s2 <= pfx;
			pfy_s2 <= pfy;
			pfz_s2 <= pfz;
			d_s2   <= plane.d;
		end
	end

	assign d_term = SW'(d_s2) <<< fct_pkg::ALIGN_SHIFT;
	assign s_term = SW'(sub_s2) << fct_pkg::ALIGN_SHIFT;
	assign sum_n  = SW'(pnx_s2) + SW'(pny_s2) + SW'(pnz_s2) + d_term - s_term;
	assign sum_f  = SW'(pfx_s2) + SW'(pfy_s2) + SW'(pfz_s2) + d_term;

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			near_gt_s3 <= sum_n > SW'(0);
			far_ge_s3  <= !sum_f[SW-1];
		end
	end
endmodule

`default_nettype wire

@@ src/frustum_culling_test_top.sv @@
// channel  dir  handshake      payload
// cfg      in   valid / ready  idx, data (one plane register)
// obj      in   valid / ready  command, x_a..z_b, radius
// res      out  valid / ready  visible, straddles
//
// One item per cycle unless res.ready stalls the output.
// Stages: input register, corner select and 36 multipliers, plane sums and
// compares, flag combine into the output register.
// arst_n clears all planes to zero and empties the pipeline.
// Each stage holds while full and its successor stalls; bubbles are absorbed.
`timescale 1ns / 1ps
`default_nettype none

module frustum_culling_test_top #(
	parameter int COORD_BITS = fct_pkg::COORD_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	fct_cfg_if.sink   cfg,
	fct_obj_if.sink   obj,
	fct_res_if.source res
);
	`include "frustum_culling_test_top_assert.svh"

	localparam int COORD_W = (COORD_BITS < fct_pkg::FIELD_W) ? COORD_BITS : fct_pkg::FIELD_W;

	fct_pkg::plane_t    planes [fct_pkg::NUM_PLANES];
	fct_pkg::stage_en_t en;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [fct_pkg::CMD_W-1:0] cmd_s1, cmd_s2, cmd_s3;
	logic signed [COORD_W-1:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;
	logic [fct_pkg::RADIUS_W-1:0] rad_s1, sub_s2;
	logic [fct_pkg::NUM_PLANES-1:0] near_gt_s3, far_ge_s3;
	logic any_gt, any_ge, vis_c, strad_c;
	logic vis_s4, strad_s4;

	fct_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.planes (planes)
	);

	assign rdy4 = !v_s4 || res.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign obj.ready = rdy1;

	assign en.en_s2 = rdy2;
	assign en.en_s3 = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= obj.valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			cmd_s1 <= obj.command;
			ax_s1  <= obj.x_a[COORD_W-1:0];
			ay_s1  <= obj.y_a[COORD_W-1:0];
			az_s1  <= obj.z_a[COORD_W-1:0];
			bx_s1  <= obj.x_b[COORD_W-1:0];
			by_s1  <= obj.y_b[COORD_W-1:0];
			bz_s1  <= obj.z_b[COORD_W-1:0];
			rad_s1 <= obj.radius;
		end
		if (rdy2) begin
			cmd_s2 <= cmd_s1;
			sub_s2 <= (cmd_s1 == fct_pkg::CMD_SPHERE) ? rad_s1 : '0;
		end
		if (rdy3) begin
			cmd_s3 <= cmd_s2;
		end
		if (rdy4) begin
			vis_s4   <= vis_c;
			strad_s4 <= strad_c;
		end
	end

	for (genvar i = 0; i < fct_pkg::NUM_PLANES; i++) begin : g_plane
		fct_plane #(
			.COORD_W (COORD_W)
		) u_plane (
			.clk        (clk),
			.en         (en),
			.plane      (planes[i]),
			.is_box_s1  (cmd_s1 == fct_pkg::CMD_BOX),
			.ax_s1      (ax_s1),
			.ay_s1      (ay_s1),
			.az_s1      (az_s1),
			.bx_s1      (bx_s1),
			.by_s1      (by_s1),
			.bz_s1      (bz_s1),
			.sub_s2     (sub_s2),
			.near_gt_s3 (near_gt_s3[i]),
			.far_ge_s3  (far_ge_s3[i])
		);
	end

	assign any_gt = |near_gt_s3;
	assign any_ge = |far_ge_s3;

	always_comb begin
		case (cmd_s3) inside
			fct_pkg::CMD_POINT, fct_pkg::CMD_SPHERE: begin
				vis_c   = !any_gt;
				strad_c = 1'b0;
			end
			fct_pkg::CMD_BOX: begin
				vis_c   = !any_gt;
				strad_c = !any_gt && any_ge;
			end
			default: begin
				vis_c   = 1'b0;
				strad_c = 1'b0;
			end
		endcase
	end

	assign res.valid     = v_s4;
	assign res.visible   = vis_s4;
	assign res.straddles = strad_s4;

	`FCT_ASSERT_IMPL(a_strad_vis, res.valid && res.straddles, res.visible, "straddling item not visible")
	`FCT_ASSERT_NEXT(a_accept_s1, obj.valid && obj.ready, v_s1, "accepted item missing from stage 1")
	`FCT_ASSERT_NEXT(a_hold_s3, v_s3 && !rdy4, v_s3 && $stable(cmd_s3) && $stable(near_gt_s3), "stage 3 lost item on stall")
	`FCT_ASSERT_NEXT(a_nobox_strad, v_s3 && rdy4 && cmd_s3 != fct_pkg::CMD_BOX, !strad_s4, "non-box item straddles")
endmodule

`default_nettype wire
